FILE: rtl/core/trapr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trapr_pkg: shared types and constants for the trapezoid setpoint ramp
// Holds the command word passed from the front end to the back end, the
// register map codes, the reset values and the back end state encoding.
// ----------------------------------------------------------------------------
package trapr_pkg;

  // Register map
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  typedef enum logic [1:0] {
    REG_TOTAL = 2'd0,
    REG_RISE  = 2'd1,
    REG_FALL  = 2'd2,
    REG_LEVEL = 2'd3
  } reg_idx_t;

  // Reset values of the configuration registers
  localparam logic [23:0] TOTAL_RST = 24'd5000;
  localparam logic [23:0] RISE_RST  = 24'd1000;
  localparam logic [23:0] FALL_RST  = 24'd1000;
  localparam logic [15:0] LEVEL_RST = 16'd0;

  // Divider: quotients always fit in 16 bits, so 16 restoring steps suffice
  localparam int QUOT_W = 16;
  localparam int DUR_W  = 24;
  localparam int PROD_W = QUOT_W + DUR_W;

  // What the back end must do with a tick
  typedef enum logic [1:0] {
    CMD_ZERO  = 2'd0,
    CMD_LEVEL = 2'd1,
    CMD_DIV   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [DUR_W-1:0]   num;
    logic [DUR_W-1:0]   den;
    logic [15:0]        level;
    logic               fin;
    logic [15:0]        runs;
  } ramp_cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_MUL  = 2'd1,
    BK_DIV  = 2'd2,
    BK_PUT  = 2'd3
  } back_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/trapr_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trapr_fifo: two-entry command queue
// Decouples the tick classifier from the arithmetic back end.
// ----------------------------------------------------------------------------
module trapr_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire trapr_pkg::ramp_cmd_t push_data,
  output logic                      full,
  input  wire logic                 pop,
  output trapr_pkg::ramp_cmd_t      pop_data,
  output logic                      empty
);

  trapr_pkg::ramp_cmd_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push && !full) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop && !empty) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if ((push && !full) && !(pop && !empty)) begin
      count_nxt = count_r + 2'd1;
    end else if (!(push && !full) && (pop && !empty)) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = entry_r[rd_ptr_r];

endmodule
`default_nettype wire

FILE: rtl/core/trapr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trapr_front: tick classifier
// Tracks the manoeuvre state, works out the elapsed time of each tick and
// turns it into a command word for the arithmetic back end.
// ----------------------------------------------------------------------------
module trapr_front #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 accept,
  input  wire logic [31:0]          now_time,
  input  wire logic [23:0]          total_time,
  input  wire logic [23:0]          rise_time,
  input  wire logic [23:0]          fall_time,
  input  wire logic [15:0]          cruise_level,
  output trapr_pkg::ramp_cmd_t      cmd
);

  logic                 active_r, active_nxt;
  logic [TIME_BITS-1:0] start_r, start_nxt;
  logic [15:0]          runs_r, runs_nxt;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] elapsed;
  logic [31:0]          elapsed_w;
  logic [23:0]          elapsed_s;
  logic [23:0]          boundary;
  logic                 done;
  logic                 in_rise;
  logic                 in_fall;

  // Elapsed time and phase tests
  always_comb begin
    now_t     = now_time[TIME_BITS-1:0];
    elapsed   = now_t - start_r;
    elapsed_w = 32'(elapsed);
    elapsed_s = elapsed_w[23:0];
    done      = elapsed_w >= 32'(total_time);
    boundary  = (fall_time > total_time) ? 24'd0 : (total_time - fall_time);
    in_rise   = elapsed_s < rise_time;
    in_fall   = (elapsed_s > boundary) && (fall_time != 24'd0);
  end

  // Build the command and the next manoeuvre state
  always_comb begin
    active_nxt = active_r;
    start_nxt  = start_r;
    runs_nxt   = runs_r;
    cmd.kind   = trapr_pkg::CMD_ZERO;
    cmd.num    = elapsed_s;
    cmd.den    = rise_time;
    cmd.level  = cruise_level;
    cmd.fin    = 1'b0;
    cmd.runs   = runs_r;
    priority if (!active_r) begin
      active_nxt = 1'b1;
      start_nxt  = now_t;
    end else if (done) begin
      active_nxt = 1'b0;
      runs_nxt   = runs_r + 16'd1;
      cmd.fin    = 1'b1;
      cmd.runs   = runs_r + 16'd1;
    end else if (in_rise) begin
      cmd.kind = trapr_pkg::CMD_DIV;
    end else if (in_fall) begin
      cmd.kind = trapr_pkg::CMD_DIV;
      cmd.num  = total_time - elapsed_s;
      cmd.den  = fall_time;
    end else begin
      cmd.kind = trapr_pkg::CMD_LEVEL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      start_r  <= '0;
      runs_r   <= 16'd0;
    end else if (accept) begin
      active_r <= active_nxt;
      start_r  <= start_nxt;
      runs_r   <= runs_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/trapr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trapr_back: setpoint arithmetic and output register
// Scales the level by the ramp time elapsed or left, divides by the ramp
// length one quotient bit per cycle (restoring), and presents the result.
// ----------------------------------------------------------------------------
module trapr_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_empty,
  input  wire trapr_pkg::ramp_cmd_t q_data,
  output logic                      q_pop,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [31:0]               out_tdata,
  output logic                      out_tlast
);

  localparam int QW = trapr_pkg::QUOT_W;
  localparam int DW = trapr_pkg::DUR_W;
  localparam int PW = trapr_pkg::PROD_W;

  trapr_pkg::back_state_t state_r, state_nxt;
  trapr_pkg::ramp_cmd_t   cmd_r, cmd_nxt;
  logic [DW-1:0]          rem_r, rem_nxt;
  logic [QW-1:0]          quo_r, quo_nxt;
  logic                   neg_r, neg_nxt;
  logic [3:0]             cnt_r, cnt_nxt;
  logic                   ovalid_r, ovalid_nxt;
  logic [31:0]            odata_r, odata_nxt;
  logic                   olast_r, olast_nxt;

  logic [15:0]            mag;
  logic [PW-1:0]          prod;
  logic [DW:0]            trial;
  logic                   ge;
  logic [15:0]            result;
  logic                   slot_free;

  // Datapath helpers
  always_comb begin
    mag    = cmd_r.level[15] ? (~cmd_r.level + 16'd1) : cmd_r.level;
    prod   = PW'(mag) * PW'(cmd_r.num);
    trial  = {rem_r, quo_r[QW-1]};
    ge     = trial >= {1'b0, cmd_r.den};
    result = neg_r ? (~quo_r + 16'd1) : quo_r;
    slot_free = !ovalid_r || out_tready;
  end

  // Sequence one command at a time
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    neg_nxt    = neg_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    q_pop      = 1'b0;
    unique case (state_r)
      trapr_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_data;
          neg_nxt = 1'b0;
          unique case (q_data.kind)
            trapr_pkg::CMD_DIV: begin
              state_nxt = trapr_pkg::BK_MUL;
              neg_nxt   = q_data.level[15];
            end
            trapr_pkg::CMD_LEVEL: begin
              state_nxt = trapr_pkg::BK_PUT;
              quo_nxt   = q_data.level;
            end
            default: begin
              state_nxt = trapr_pkg::BK_PUT;
              quo_nxt   = '0;
            end
          endcase
        end
      end
      trapr_pkg::BK_MUL: begin
        // Upper product bits are already below the divisor
        rem_nxt   = prod[PW-1:QW];
        quo_nxt   = prod[QW-1:0];
        cnt_nxt   = 4'(QW - 1);
        state_nxt = trapr_pkg::BK_DIV;
      end
      trapr_pkg::BK_DIV: begin
        rem_nxt = ge ? DW'(trial - {1'b0, cmd_r.den}) : trial[DW-1:0];
        quo_nxt = {quo_r[QW-2:0], ge};
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          state_nxt = trapr_pkg::BK_PUT;
        end
      end
      trapr_pkg::BK_PUT: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = {cmd_r.runs, result};
          olast_nxt  = cmd_r.fin;
          state_nxt  = trapr_pkg::BK_IDLE;
        end
      end
      default: state_nxt = trapr_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= trapr_pkg::BK_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    neg_r   <= neg_nxt;
    cnt_r   <= cnt_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

endmodule
`default_nettype wire

FILE: rtl/core/trapezoid_setpoint_ramp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trapezoid_setpoint_ramp: trapezoidal setpoint profile, one channel
// Each input word is one control-loop tick carrying a millisecond time stamp;
// each tick yields one output word holding the setpoint, the completed-run
// count and, on tlast, the end of a manoeuvre. The front end takes a tick
// whenever the two-entry command queue has room. The back end handles one
// command at a time: a divide command passes queue read, one 16x24 multiply,
// 16 restoring divider steps and output load; a hold-level or zero command
// goes from queue read to output load. The serial divider therefore sets the
// sustained rate in the ramps. Registers are to be written over the APB-style
// port only while no tick is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module trapezoid_setpoint_ramp #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Tick input
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [31:0]                  in_tdata,   // [31:0] now_time
  // Setpoint output
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [31:0]                       out_tdata,  // [15:0] setpoint, [31:16] runs_done
  output logic                              out_tlast,  // finished
  // Configuration port
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [trapr_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [trapr_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [trapr_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                              cfg_pready
);

  logic [23:0] total_r;
  logic [23:0] rise_r;
  logic [23:0] fall_r;
  logic [15:0] level_r;

  trapr_pkg::reg_idx_t  reg_sel;
  logic                 cfg_wr;
  logic                 in_accept;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;
  trapr_pkg::ramp_cmd_t front_cmd;
  trapr_pkg::ramp_cmd_t q_data;

  assign cfg_pready = 1'b1;
  assign reg_sel    = trapr_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= trapr_pkg::TOTAL_RST;
      rise_r  <= trapr_pkg::RISE_RST;
      fall_r  <= trapr_pkg::FALL_RST;
      level_r <= trapr_pkg::LEVEL_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        trapr_pkg::REG_TOTAL: total_r <= cfg_pwdata[23:0];
        trapr_pkg::REG_RISE:  rise_r  <= cfg_pwdata[23:0];
        trapr_pkg::REG_FALL:  fall_r  <= cfg_pwdata[23:0];
        trapr_pkg::REG_LEVEL: level_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_sel)
      trapr_pkg::REG_TOTAL: cfg_prdata = 32'(total_r);
      trapr_pkg::REG_RISE:  cfg_prdata = 32'(rise_r);
      trapr_pkg::REG_FALL:  cfg_prdata = 32'(fall_r);
      trapr_pkg::REG_LEVEL: cfg_prdata = 32'(level_r);
      default:              cfg_prdata = '0;
    endcase
  end

  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  trapr_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .now_time     (in_tdata),
    .total_time   (total_r),
    .rise_time    (rise_r),
    .fall_time    (fall_r),
    .cruise_level (level_r),
    .cmd          (front_cmd)
  );

  trapr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  trapr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
